[sv/bmp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp_pkg
// Shared constants for the binary mask pyramid block: result field widths,
// configuration and APB widths, front-to-back queue depth and sizer area limit.
// ----------------------------------------------------------------------------
package bmp_pkg;

	localparam int CFG_W      = 12;
	localparam int CAM_W      = 3;
	localparam int LEVEL_W    = 3;
	localparam int POS_W      = 10;
	localparam int APB_AW     = 4;
	localparam int APB_DW     = 32;

	localparam int QDEPTH     = 8;
	localparam int QAW        = 3;
	localparam int QCW        = 4;

	localparam logic [31:0] AREA_LIMIT = 32'd5000;

endpackage

[sv/binary_mask_pyramid_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_mask_pyramid_top
// Builds AND-pooled 2x2 pyramid levels from a raster stream of mask pixels.
// ----------------------------------------------------------------------------
// One mask pixel is taken per cycle while in_ready is high. Level 0 is paired
// on the input side; each completed level-1 bit enters an 8-entry queue, and
// a level sequencer walks up the pyramid one level per cycle while the output
// is not stalled, so a pixel that completes k coarse bits gives k result
// transactions in a row, lowest level first, last one flagged. The output side
// delivers at most one result per cycle; in_ready drops when the queue,
// with a bit in flight counted, is full, and while the level sizer runs: after
// reset and after every width or height write it finds the level count, one
// level per cycle with one multiply and compare.
module binary_mask_pyramid_top #(
	parameter int LEVEL_LIMIT = 6,
	parameter int MAX_WIDTH   = 2048,
	parameter int MAX_HEIGHT  = 2048
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bmp_pkg::APB_AW-1:0]  paddr,
	input  logic [bmp_pkg::APB_DW-1:0]  pwdata,
	output logic [bmp_pkg::APB_DW-1:0]  prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        mask_bit,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [bmp_pkg::CAM_W-1:0]   camera,
	output logic [bmp_pkg::LEVEL_W-1:0] level,
	output logic [bmp_pkg::POS_W-1:0]   column,
	output logic [bmp_pkg::POS_W-1:0]   row,
	output logic                        keep,
	output logic                        last
);
	import bmp_pkg::*;

	localparam int EW = $clog2(MAX_WIDTH+1);
	localparam int EH = $clog2(MAX_HEIGHT+1);
	localparam int LW = $clog2(LEVEL_LIMIT+1);
	localparam int AW = $clog2(MAX_WIDTH/2);

	logic          restart;
	logic          sizing;
	logic [LW-1:0] levels;
	logic [EW-1:0] ew;
	logic [EH-1:0] eh;
	logic [LEVEL_LIMIT-1:0][AW-1:0] boff;
	logic [QCW-1:0] q_count;
	logic          q_push;
	logic          q_push_bit;
	logic          q_pop;
	logic          q_valid;
	logic          q_bit;

	bmp_cfg #(
		.LEVEL_LIMIT(LEVEL_LIMIT),
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.restart (restart),
		.sizing  (sizing),
		.levels  (levels),
		.ew      (ew),
		.eh      (eh),
		.boff    (boff),
		.camera  (camera)
	);

	bmp_front #(
		.LEVEL_LIMIT(LEVEL_LIMIT),
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.mask_bit (mask_bit),
		.restart  (restart),
		.sizing   (sizing),
		.levels   (levels),
		.ew       (ew),
		.eh       (eh),
		.q_count  (q_count),
		.q_push   (q_push),
		.q_bit    (q_push_bit)
	);

	bmp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_bit   (q_push_bit),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head_bit   (q_bit),
		.count      (q_count)
	);

	bmp_back #(
		.LEVEL_LIMIT(LEVEL_LIMIT),
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.restart   (restart),
		.levels    (levels),
		.ew        (ew),
		.eh        (eh),
		.boff      (boff),
		.q_valid   (q_valid),
		.q_bit     (q_bit),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.level     (level),
		.column    (column),
		.row       (row),
		.keep      (keep),
		.last      (last)
	);

	a_queue_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> (q_count < QCW'(QDEPTH)))
		else $error("queue push while full");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((level != '0) && (LW'(level) < levels)))
		else $error("result level outside levels in use");

	a_sizing_stall: assert property (@(posedge clk) disable iff (!arst_n)
		sizing |-> !in_ready)
		else $error("input taken while sizing levels");

	a_cascade_gapless: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !last) |=> out_valid)
		else $error("gap inside one transaction's result burst");

endmodule

[sv/bmp_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp_cfg
// Register file on the APB-style port and level sizer: clamps the frame size
// and finds the number of pyramid levels and the line store offsets, one
// level per cycle after reset or a size write.
// ----------------------------------------------------------------------------
module bmp_cfg #(
	parameter int LEVEL_LIMIT = 6,
	parameter int MAX_WIDTH   = 2048,
	parameter int MAX_HEIGHT  = 2048
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       psel,
	input  logic                                       penable,
	input  logic                                       pwrite,
	input  logic [bmp_pkg::APB_AW-1:0]                 paddr,
	input  logic [bmp_pkg::APB_DW-1:0]                 pwdata,
	output logic [bmp_pkg::APB_DW-1:0]                 prdata,
	output logic                                       pready,
	output logic                                       restart,
	output logic                                       sizing,
	output logic [$clog2(LEVEL_LIMIT+1)-1:0]           levels,
	output logic [$clog2(MAX_WIDTH+1)-1:0]             ew,
	output logic [$clog2(MAX_HEIGHT+1)-1:0]            eh,
	output logic [LEVEL_LIMIT-1:0][$clog2(MAX_WIDTH/2)-1:0] boff,
	output logic [bmp_pkg::CAM_W-1:0]                  camera
);
	import bmp_pkg::*;

	localparam int EW = $clog2(MAX_WIDTH+1);
	localparam int EH = $clog2(MAX_HEIGHT+1);
	localparam int LW = $clog2(LEVEL_LIMIT+1);
	localparam int IW = $clog2(LEVEL_LIMIT);
	localparam int AW = $clog2(MAX_WIDTH/2);
	localparam int DW = (EW > CFG_W) ? EW : CFG_W;
	localparam int DH = (EH > CFG_W) ? EH : CFG_W;
	localparam int PW = EW + EH;

	localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [1:0] REG_CAMERA_TAG   = 2'd2;

	logic [CFG_W-1:0] width_q;
	logic [CFG_W-1:0] height_q;
	logic [CAM_W-1:0] camera_q;
	logic             sizing_q;
	logic             init_q;
	logic [LW-1:0]    levels_q;
	logic [EW-1:0]    wl_q;
	logic [EH-1:0]    hl_q;
	logic [AW-1:0]    acc_q;
	logic [LEVEL_LIMIT-1:0][AW-1:0] boff_q;

	logic          wr;
	logic [1:0]    widx;
	logic [DW-1:0] wx;
	logic [DH-1:0] hx;
	logic [PW-1:0] area;
	logic          grow;
	logic [EW-1:0] w_half;
	logic [AW-1:0] acc_nx;

	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite;
	assign widx   = paddr[3:2];
	assign restart = wr && (widx == REG_IMAGE_WIDTH || widx == REG_IMAGE_HEIGHT);

	always_comb begin
		unique case (widx)
			REG_IMAGE_WIDTH:  prdata = APB_DW'(width_q);
			REG_IMAGE_HEIGHT: prdata = APB_DW'(height_q);
			REG_CAMERA_TAG:   prdata = APB_DW'(camera_q);
			default:          prdata = '0;
		endcase
	end

	// clamp to 1..max
	assign wx = DW'(width_q);
	assign hx = DH'(height_q);
	assign ew = (wx == '0) ? EW'(1) : (wx > DW'(MAX_WIDTH)) ? EW'(MAX_WIDTH) : EW'(wx);
	assign eh = (hx == '0) ? EH'(1) : (hx > DH'(MAX_HEIGHT)) ? EH'(MAX_HEIGHT) : EH'(hx);

	assign area   = PW'(wl_q) * PW'(hl_q);
	assign grow   = !wl_q[0] && !hl_q[0] && (32'(area) > AREA_LIMIT) &&
		(levels_q < LW'(LEVEL_LIMIT));
	assign w_half = wl_q >> 1;
	assign acc_nx = (levels_q >= LW'(2)) ? acc_q + AW'(w_half) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_W'(640);
			height_q <= CFG_W'(480);
			camera_q <= '0;
			sizing_q <= 1'b1;
			init_q   <= 1'b1;
			levels_q <= LW'(1);
		end else begin
			if (wr) begin
				unique case (widx)
					REG_IMAGE_WIDTH:  width_q  <= pwdata[CFG_W-1:0];
					REG_IMAGE_HEIGHT: height_q <= pwdata[CFG_W-1:0];
					REG_CAMERA_TAG:   camera_q <= pwdata[CAM_W-1:0];
					default:          ;
				endcase
			end
			if (restart) begin
				sizing_q <= 1'b1;
				init_q   <= 1'b1;
			end else if (sizing_q && init_q) begin
				init_q   <= 1'b0;
				levels_q <= LW'(1);
			end else if (sizing_q) begin
				if (grow) begin
					levels_q <= levels_q + LW'(1);
				end else begin
					sizing_q <= 1'b0;
				end
			end
		end
	end

	// sizer datapath
	always_ff @(posedge clk) begin
		if (sizing_q && init_q) begin
			wl_q  <= ew;
			hl_q  <= eh;
			acc_q <= '0;
		end else if (sizing_q && grow) begin
			wl_q  <= w_half;
			hl_q  <= hl_q >> 1;
			acc_q <= acc_nx;
			boff_q[IW'(levels_q)] <= acc_nx;
		end
	end

	assign sizing = sizing_q;
	assign levels = levels_q;
	assign boff   = boff_q;
	assign camera = camera_q;

endmodule

[sv/bmp_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp_front
// Input side: accepts level-0 mask pixels, tracks the level-0 position,
// pairs pixels horizontally and, through its own line store, vertically,
// and hands each completed level-1 bit to the queue.
// ----------------------------------------------------------------------------
module bmp_front #(
	parameter int LEVEL_LIMIT = 6,
	parameter int MAX_WIDTH   = 2048,
	parameter int MAX_HEIGHT  = 2048
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              mask_bit,
	input  logic                              restart,
	input  logic                              sizing,
	input  logic [$clog2(LEVEL_LIMIT+1)-1:0]  levels,
	input  logic [$clog2(MAX_WIDTH+1)-1:0]    ew,
	input  logic [$clog2(MAX_HEIGHT+1)-1:0]   eh,
	input  logic [bmp_pkg::QCW-1:0]           q_count,
	output logic                              q_push,
	output logic                              q_bit
);
	import bmp_pkg::*;

	localparam int EW = $clog2(MAX_WIDTH+1);
	localparam int EH = $clog2(MAX_HEIGHT+1);
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int LW = $clog2(LEVEL_LIMIT+1);
	localparam int MD = MAX_WIDTH/2;
	localparam int AW = $clog2(MD);

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic          pend_q;
	logic          ev_s1;
	logic          pair_s1;
	logic          rd_q;
	logic          line_mem [MD];

	logic          accept;
	logic          paired;
	logic [EW-1:0] col_nx;
	logic [EH-1:0] row_nx;
	logic [AW-1:0] idx;
	logic          pair;

	assign in_ready = !sizing && ((q_count + QCW'(ev_s1)) < QCW'(QDEPTH));
	assign accept   = in_valid & in_ready;
	assign paired   = (levels > LW'(1)) && col_q[0];
	assign col_nx   = EW'(col_q) + EW'(1);
	assign row_nx   = EH'(row_q) + EH'(1);
	assign idx      = col_q[AW:1];
	assign pair     = pend_q & mask_bit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			pend_q <= 1'b0;
			ev_s1  <= 1'b0;
		end else if (restart) begin
			col_q  <= '0;
			row_q  <= '0;
			pend_q <= 1'b0;
			ev_s1  <= 1'b0;
		end else begin
			ev_s1 <= accept && paired && row_q[0];
			if (accept) begin
				if (col_nx >= ew) begin
					col_q <= '0;
					row_q <= (row_nx >= eh) ? '0 : RW'(row_nx);
				end else begin
					col_q <= CW'(col_nx);
				end
				if ((levels > LW'(1)) && !col_q[0]) begin
					pend_q <= mask_bit;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && paired) begin
			pair_s1 <= pair;
			if (!row_q[0]) begin
				line_mem[idx] <= pair;
			end else begin
				rd_q <= line_mem[idx];
			end
		end
	end

	assign q_push = ev_s1;
	assign q_bit  = pair_s1 & rd_q;

endmodule

[sv/bmp_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp_queue
// Short FIFO of level-1 bits between the input side and the level
// sequencer, so that each side stalls on its own.
// ----------------------------------------------------------------------------
module bmp_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  logic                    push_bit,
	input  logic                    pop,
	output logic                    head_valid,
	output logic                    head_bit,
	output logic [bmp_pkg::QCW-1:0] count
);
	import bmp_pkg::*;

	logic [QDEPTH-1:0] bits_q;
	logic [QAW-1:0]    wr_ptr_q;
	logic [QAW-1:0]    rd_ptr_q;
	logic [QCW-1:0]    count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			priority case (1'b1)
				push && !pop: count_q <= count_q + QCW'(1);
				pop && !push: count_q <= count_q - QCW'(1);
				default:      ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			bits_q[wr_ptr_q] <= push_bit;
		end
	end

	assign head_valid = (count_q != '0);
	assign head_bit   = bits_q[rd_ptr_q];
	assign count      = count_q;

endmodule

[sv/bmp_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp_back
// Level sequencer: takes level-1 bits from the queue and walks up the
// pyramid one level per cycle while the output is not stalled, emitting one
// result transaction per level through the output register and pairing bits
// through the shared line store of the coarser levels.
// ----------------------------------------------------------------------------
module bmp_back #(
	parameter int LEVEL_LIMIT = 6,
	parameter int MAX_WIDTH   = 2048,
	parameter int MAX_HEIGHT  = 2048
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  logic                                            restart,
	input  logic [$clog2(LEVEL_LIMIT+1)-1:0]                levels,
	input  logic [$clog2(MAX_WIDTH+1)-1:0]                  ew,
	input  logic [$clog2(MAX_HEIGHT+1)-1:0]                 eh,
	input  logic [LEVEL_LIMIT-1:0][$clog2(MAX_WIDTH/2)-1:0] boff,
	input  logic                                            q_valid,
	input  logic                                            q_bit,
	output logic                                            q_pop,
	output logic                                            out_valid,
	input  logic                                            out_ready,
	output logic [bmp_pkg::LEVEL_W-1:0]                     level,
	output logic [bmp_pkg::POS_W-1:0]                       column,
	output logic [bmp_pkg::POS_W-1:0]                       row,
	output logic                                            keep,
	output logic                                            last
);
	import bmp_pkg::*;

	localparam int EW = $clog2(MAX_WIDTH+1);
	localparam int EH = $clog2(MAX_HEIGHT+1);
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int LW = $clog2(LEVEL_LIMIT+1);
	localparam int IW = $clog2(LEVEL_LIMIT);
	localparam int MD = MAX_WIDTH/2;
	localparam int AW = $clog2(MD);

	logic [CW-1:0] col_q  [LEVEL_LIMIT];
	logic [RW-1:0] row_q  [LEVEL_LIMIT];
	logic          pend_q [LEVEL_LIMIT];
	logic          cont_q;
	logic [IW-1:0] cont_lv_q;
	logic          pair_q;
	logic          rd_q;
	logic          out_valid_q;
	logic [LEVEL_W-1:0] level_q;
	logic [POS_W-1:0]   column_q;
	logic [POS_W-1:0]   row_o_q;
	logic          keep_q;
	logic          last_q;
	logic          line_mem [MD];

	logic          step;
	logic [IW-1:0] lv;
	logic          b;
	logic [CW-1:0] col;
	logic [RW-1:0] rw;
	logic          pend;
	logic [EW-1:0] wl;
	logic [EH-1:0] hl;
	logic [EW-1:0] col_nx;
	logic [EH-1:0] row_nx;
	logic          use_store;
	logic          more;
	logic [AW-1:0] idx;

	assign step      = (cont_q || q_valid) && (!out_valid_q || out_ready);
	assign lv        = cont_q ? cont_lv_q : IW'(1);
	assign b         = cont_q ? (pair_q & rd_q) : q_bit;
	assign col       = col_q[lv];
	assign rw        = row_q[lv];
	assign pend      = pend_q[lv];
	assign wl        = ew >> lv;
	assign hl        = eh >> lv;
	assign col_nx    = EW'(col) + EW'(1);
	assign row_nx    = EH'(rw) + EH'(1);
	assign use_store = (LW'(lv) + LW'(1)) < levels;
	assign more      = use_store && col[0] && rw[0];
	assign idx       = boff[lv] + col[AW:1];
	assign q_pop     = step && !cont_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LEVEL_LIMIT; i++) begin
				col_q[i]  <= '0;
				row_q[i]  <= '0;
				pend_q[i] <= 1'b0;
			end
			cont_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (restart) begin
			for (int i = 0; i < LEVEL_LIMIT; i++) begin
				col_q[i]  <= '0;
				row_q[i]  <= '0;
				pend_q[i] <= 1'b0;
			end
			cont_q <= 1'b0;
		end else if (step) begin
			if (col_nx >= wl) begin
				col_q[lv] <= '0;
				row_q[lv] <= (row_nx >= hl) ? '0 : RW'(row_nx);
			end else begin
				col_q[lv] <= CW'(col_nx);
			end
			if (use_store && !col[0]) begin
				pend_q[lv] <= b;
			end
			cont_q      <= more;
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			cont_lv_q <= lv + IW'(1);
			pair_q    <= pend & b;
			level_q   <= LEVEL_W'(lv);
			column_q  <= POS_W'(col);
			row_o_q   <= POS_W'(rw);
			keep_q    <= b;
			last_q    <= !more;
			if (use_store && col[0]) begin
				if (!rw[0]) begin
					line_mem[idx] <= pend & b;
				end else begin
					rd_q <= line_mem[idx];
				end
			end
		end
	end

	assign out_valid = out_valid_q;
	assign level     = level_q;
	assign column    = column_q;
	assign row       = row_o_q;
	assign keep      = keep_q;
	assign last      = last_q;

endmodule
